>>> rtl/mvf_pkg.sv
// Shared types, codes and the X.25 checksum step for the packet framer.
// No dependencies; imported by mavlink_v1_packet_framer.
package mvf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CrcW-1:0] CRC_SEED = 16'hFFFF;

  // Configuration register indices
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER     = 3'd0,
    CFG_SENDER_SYSTEM    = 3'd1,
    CFG_SENDER_COMPONENT = 3'd2,
    CFG_TARGET_SYSTEM    = 3'd3,
    CFG_TARGET_COMPONENT = 3'd4,
    CFG_CRC_EXTRA        = 3'd5
  } cfg_reg_t;

  // Place of a beat within the frame produced by one input item
  typedef enum logic [3:0] {
    POS_MARKER     = 4'd0,
    POS_LENGTH     = 4'd1,
    POS_SEQ        = 4'd2,
    POS_SENDER_SYS = 4'd3,
    POS_SENDER_CMP = 4'd4,
    POS_TARGET_SYS = 4'd5,
    POS_TARGET_CMP = 4'd6,
    POS_MSG_ID     = 4'd7,
    POS_DATA       = 4'd8,
    POS_CRC_LO     = 4'd9,
    POS_CRC_HI     = 4'd10
  } pos_t;

  // One byte of the X.25 (MCRF4XX) checksum
  function automatic logic [CrcW-1:0] x25_add(input logic [CrcW-1:0] crc,
                                              input logic [ByteW-1:0] data);
    logic [ByteW-1:0] t;
    t = data ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
           ^ {12'h000, t[7:4]};
  endfunction

endpackage

>>> rtl/mavlink_v1_packet_framer.sv
// Packet framer top level: slot register, beat sequencer and output register.
// Depends on mvf_pkg (types, codes, checksum step).
//
// Usage
// - Input channel (pay_valid/pay_ready): one payload byte per beat, with the
//   packet length and message id; first_byte opens a new packet.
// - Output channel (wire_valid/wire_ready): one framed byte per beat.
//   end_of_run marks the last beat caused by an input item, end_of_packet
//   the high checksum byte.
// - Config port (cfg_we/cfg_index/cfg_data): to be written while idle only; the block does not enforce it.
// - The first beat of an item goes from the slot register into the output
//   register; a receiver stall can hold it in the slot.
// - Beats per item: a plain payload byte gives one beat; the first byte of a
//   packet gives nine (header plus byte), the last one three (byte plus
//   checksum) and a one-byte packet eleven. The rate is set by the single
//   output register, one byte per cycle unless the receiver stalls.
// - Items that open a zero-length packet or arrive outside a packet are
//   accepted and dropped without output.
// - Reset clears the sequence number and the byte count, seeds the checksum
//   with FFFF and loads the default config. When the receiver stalls, the
//   output beat holds and the slot register behind it holds the next item,
//   so input stalls once the slot is full.
module mavlink_v1_packet_framer (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [mvf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mvf_pkg::ByteW-1:0]     cfg_data,
  // payload input
  input  logic                          pay_valid,
  output logic                          pay_ready,
  input  logic [mvf_pkg::ByteW-1:0]     payload_byte,
  input  logic [mvf_pkg::ByteW-1:0]     payload_length,
  input  logic [mvf_pkg::ByteW-1:0]     message_id,
  input  logic                          first_byte,
  // framed output
  output logic                          wire_valid,
  input  logic                          wire_ready,
  output logic [mvf_pkg::ByteW-1:0]     out_byte,
  output logic                          end_of_run,
  output logic                          end_of_packet
);
  import mvf_pkg::*;

  // config registers
  logic [ByteW-1:0] start_marker, sender_system, sender_component;
  logic [ByteW-1:0] target_system, target_component, crc_extra_byte;

  // packet state on the accept side
  logic [ByteW-1:0] sequence_number;
  logic [ByteW-1:0] bytes_remaining, bytes_remaining_next;
  logic [CrcW-1:0]  running_crc, running_crc_next;

  // slot register: the item whose beats are being sent
  logic             slot_valid;
  logic             slot_last;
  pos_t             slot_pos;
  logic [ByteW-1:0] slot_data, slot_len, slot_msg, slot_seq;

  logic             accept, productive, advance, slot_done;
  pos_t             end_pos;
  logic [ByteW-1:0] beat_byte;
  logic [CrcW-1:0]  crc_fold_extra;

  // handshake
  assign advance   = slot_valid && (!wire_valid || wire_ready);
  assign end_pos   = slot_last ? POS_CRC_HI : POS_DATA;
  assign slot_done = advance && (slot_pos == end_pos);
  assign pay_ready = !slot_valid || slot_done;
  assign accept    = pay_valid && pay_ready;

  // item classification and byte count update
  always_comb begin
    productive           = 1'b0;
    bytes_remaining_next = bytes_remaining;
    if (first_byte) begin
      if (payload_length != '0) begin
        productive           = 1'b1;
        bytes_remaining_next = payload_length - 8'd1;
      end
    end else if (bytes_remaining != '0) begin
      productive           = 1'b1;
      bytes_remaining_next = bytes_remaining - 8'd1;
    end
  end

  // config writes; other indices are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker     <= 8'd254;
      sender_system    <= 8'd1;
      sender_component <= 8'd0;
      target_system    <= 8'd2;
      target_component <= 8'd0;
      crc_extra_byte   <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER:     start_marker     <= cfg_data;
        CFG_SENDER_SYSTEM:    sender_system    <= cfg_data;
        CFG_SENDER_COMPONENT: sender_component <= cfg_data;
        CFG_TARGET_SYSTEM:    target_system    <= cfg_data;
        CFG_TARGET_COMPONENT: target_component <= cfg_data;
        CFG_CRC_EXTRA:        crc_extra_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept side state
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
      bytes_remaining <= '0;
    end else if (accept && productive) begin
      bytes_remaining <= bytes_remaining_next;
      if (first_byte) begin
        sequence_number <= sequence_number + 8'd1;
      end
    end
  end

  // slot control
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_pos   <= POS_MARKER;
    end else if (accept && productive) begin
      slot_valid <= 1'b1;
      slot_pos   <= first_byte ? POS_MARKER : POS_DATA;
    end else if (slot_done) begin
      slot_valid <= 1'b0;
    end else if (advance) begin
      slot_pos   <= pos_t'(slot_pos + 4'd1);
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (accept && productive) begin
      slot_data <= payload_byte;
      slot_len  <= payload_length;
      slot_msg  <= message_id;
      slot_seq  <= sequence_number;
      slot_last <= (bytes_remaining_next == '0);
    end
  end

  // beat selection and checksum step
  assign crc_fold_extra = x25_add(running_crc, crc_extra_byte);

  always_comb begin
    unique case (slot_pos)
      POS_MARKER:     beat_byte = start_marker;
      POS_LENGTH:     beat_byte = slot_len;
      POS_SEQ:        beat_byte = slot_seq;
      POS_SENDER_SYS: beat_byte = sender_system;
      POS_SENDER_CMP: beat_byte = sender_component;
      POS_TARGET_SYS: beat_byte = target_system;
      POS_TARGET_CMP: beat_byte = target_component;
      POS_MSG_ID:     beat_byte = slot_msg;
      POS_DATA:       beat_byte = slot_data;
      POS_CRC_LO:     beat_byte = crc_fold_extra[7:0];
      POS_CRC_HI:     beat_byte = running_crc[15:8];
      default:        beat_byte = '0;
    endcase
    running_crc_next = x25_add(running_crc, beat_byte);
    // marker is not covered; checksum restarts after the high byte
    if (slot_pos == POS_MARKER || slot_pos == POS_CRC_HI) begin
      running_crc_next = CRC_SEED;
    end else if (slot_pos == POS_CRC_LO) begin
      running_crc_next = crc_fold_extra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_SEED;
    end else if (advance) begin
      running_crc <= running_crc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      wire_valid <= 1'b0;
    end else if (advance) begin
      wire_valid <= 1'b1;
    end else if (wire_ready) begin
      wire_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= beat_byte;
      end_of_run    <= (slot_pos == end_pos);
      end_of_packet <= (slot_pos == POS_CRC_HI);
    end
  end

`ifndef SYNTHESIS
  // checksum high byte always closes the run of its item
  a_eop_ends_run: assert property (@(posedge clk) disable iff (rst)
    wire_valid && end_of_packet |-> end_of_run)
    else $error("end_of_packet without end_of_run");

  // an empty slot never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !slot_valid |-> pay_ready)
    else $error("input stalled with empty slot");

  // checksum restarts once the packet is closed
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    advance && slot_pos == POS_CRC_HI |=> running_crc == CRC_SEED)
    else $error("checksum not restarted after packet");

  // an item that does not end its packet never reaches the checksum beats
  a_no_crc_midpacket: assert property (@(posedge clk) disable iff (rst)
    slot_valid && !slot_last |-> slot_pos != POS_CRC_LO && slot_pos != POS_CRC_HI)
    else $error("checksum beat inside packet");
`endif

endmodule

>>> dv/tb_mavlink_v1_packet_framer.sv
// Self-checking testbench for mavlink_v1_packet_framer: directed and random
// payload traffic, header/checksum prediction and beat-by-beat output checks.
// Depends on mvf_pkg and the framer RTL only.
`timescale 1ns / 100ps

module tb_mavlink_v1_packet_framer;
  import mvf_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 80;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_LIMIT   = 4000;

  // Indices with no register behind them; writes there must be harmless
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  // Reflected form of the CCITT polynomial, as used by the X.25 checksum
  localparam logic [CrcW-1:0] CRC_POLY_REFL = 16'h8408;

  // Register values after reset
  localparam logic [ByteW-1:0] RST_MARKER   = 8'd254;
  localparam logic [ByteW-1:0] RST_SRC_SYS  = 8'd1;
  localparam logic [ByteW-1:0] RST_SRC_COMP = 8'd0;
  localparam logic [ByteW-1:0] RST_DST_SYS  = 8'd2;
  localparam logic [ByteW-1:0] RST_DST_COMP = 8'd0;
  localparam logic [ByteW-1:0] RST_EXTRA    = 8'd0;

  typedef struct packed {
    logic [ByteW-1:0] octet;
    logic             run_end;
    logic             pkt_end;
  } wire_beat_t;

  // DUT signals; the inputs are known from time zero
  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_we         = 1'b0;
  logic [CfgIdxW-1:0] cfg_index      = '0;
  logic [ByteW-1:0]   cfg_data       = '0;
  logic               pay_valid      = 1'b0;
  logic               pay_ready;
  logic [ByteW-1:0]   payload_byte   = '0;
  logic [ByteW-1:0]   payload_length = '0;
  logic [ByteW-1:0]   message_id     = '0;
  logic               first_byte     = 1'b0;
  logic               wire_valid;
  logic               wire_ready     = 1'b1;
  logic [ByteW-1:0]   out_byte;
  logic               end_of_run;
  logic               end_of_packet;

  // Framer state as the testbench sees it
  logic [ByteW-1:0] seq_num;
  logic [CrcW-1:0]  frame_crc;
  logic [ByteW-1:0] bytes_left;
  logic             seq_wrapped;
  logic [ByteW-1:0] reg_marker;
  logic [ByteW-1:0] reg_src_sys;
  logic [ByteW-1:0] reg_src_comp;
  logic [ByteW-1:0] reg_dst_sys;
  logic [ByteW-1:0] reg_dst_comp;
  logic [ByteW-1:0] reg_crc_extra;

  wire_beat_t frame_q[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  logic       idle_on     = 1'b1;

  mavlink_v1_packet_framer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pay_valid      (pay_valid),
    .pay_ready      (pay_ready),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .message_id     (message_id),
    .first_byte     (first_byte),
    .wire_valid     (wire_valid),
    .wire_ready     (wire_ready),
    .out_byte       (out_byte),
    .end_of_run     (end_of_run),
    .end_of_packet  (end_of_packet)
  );

  always #4 clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mavlink_v1_packet_framer verification failed");
      $finish;
    end
  end

  // Bitwise X.25 / MCRF4XX update, one byte LSB first
  function automatic logic [CrcW-1:0] crc_mcrf4xx(input logic [CrcW-1:0] crc,
                                                  input logic [ByteW-1:0] d);
    logic [CrcW-1:0] c;
    int k;
    c = crc ^ {8'h00, d};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // Works out the wire beats caused by one accepted payload beat and queues
  // them; returns how many there are
  function automatic int predict_frame(input logic [ByteW-1:0] data,
                                       input logic [ByteW-1:0] len,
                                       input logic [ByteW-1:0] msg,
                                       input logic is_first);
    logic [ByteW-1:0] hdr [8];
    logic [CrcW-1:0]  fin;
    int k;
    int n;
    n = 0;
    if (is_first) begin
      // zero-length opener is dropped with no effect at all
      if (len == 0) return 0;
      hdr[0] = reg_marker;
      hdr[1] = len;
      hdr[2] = seq_num;
      hdr[3] = reg_src_sys;
      hdr[4] = reg_src_comp;
      hdr[5] = reg_dst_sys;
      hdr[6] = reg_dst_comp;
      hdr[7] = msg;
      if (seq_num == 8'hFF) seq_wrapped = 1'b1;
      seq_num   = seq_num + 8'd1;
      frame_crc = CRC_SEED;
      for (k = 0; k < 8; k++) begin
        // marker is not covered by the checksum
        if (k > 0) frame_crc = crc_mcrf4xx(frame_crc, hdr[k]);
        frame_q.push_back({hdr[k], 1'b0, 1'b0});
        n++;
      end
      bytes_left = len;
    end else if (bytes_left == 0) begin
      // stray byte outside any packet
      return 0;
    end

    frame_crc  = crc_mcrf4xx(frame_crc, data);
    bytes_left = bytes_left - 8'd1;
    frame_q.push_back({data, (bytes_left != 0), 1'b0});
    n++;

    // packet complete: checksum with the extra byte folded in, low byte first
    if (bytes_left == 0) begin
      fin = crc_mcrf4xx(frame_crc, reg_crc_extra);
      frame_q.push_back({fin[7:0], 1'b0, 1'b0});
      frame_q.push_back({fin[15:8], 1'b1, 1'b1});
      frame_crc = CRC_SEED;
      n += 2;
    end
    return n;
  endfunction

  function automatic void report_mismatch(input string what, input wire_beat_t want,
                                          input wire_beat_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected byte %02h eor %0b eop %0b, got byte %02h eor %0b eop %0b",
               $realtime, what, want.octet, want.run_end, want.pkt_end,
               got.octet, got.run_end, got.pkt_end);
  endfunction

  // Output checker: signals are settled mid-cycle, the beat is taken at the
  // next rising edge
  always @(negedge clk) begin
    wire_beat_t want;
    wire_beat_t got;
    if (!rst && wire_valid && wire_ready) begin
      got = {out_byte, end_of_run, end_of_packet};
      if (frame_q.size() == 0) begin
        report_mismatch("beat with nothing expected", '0, got);
      end else begin
        want = frame_q.pop_front();
        if (got.octet !== want.octet || got.run_end !== want.run_end ||
            got.pkt_end !== want.pkt_end)
          report_mismatch("wire beat mismatch", want, got);
      end
    end
  end

  // Receiver: random stall bursts while idling is allowed
  initial begin
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (idle_on && $urandom_range(0, 1) == 1) begin
        wire_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        wire_ready <= 1'b1;
      end
    end
  end

  // Sends one payload beat; returns the number of wire beats it causes.
  // Called and returns on a rising edge.
  task automatic send_item(input logic [ByteW-1:0] data, input logic [ByteW-1:0] len,
                           input logic [ByteW-1:0] msg, input logic is_first,
                           output int n_beats);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pay_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    payload_byte   <= data;
    payload_length <= len;
    message_id     <= msg;
    first_byte     <= is_first;
    pay_valid      <= 1'b1;
    do @(negedge clk); while (!pay_ready);
    @(posedge clk);
    n_beats = predict_frame(data, len, msg, is_first);
  endtask

  // Opens a packet of len bytes and sends the first 'sent' of them; later
  // beats carry junk length and id, which must be ignored
  task automatic send_packet(input int len, input logic [ByteW-1:0] msg, input int sent,
                             output int taken);
    int k;
    int n;
    taken = 0;
    for (k = 0; k < sent; k++) begin
      if (k == 0)
        send_item(8'($urandom_range(0, 255)), len[ByteW-1:0], msg, 1'b1, n);
      else
        send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, n);
      if (n > 0) taken++;
    end
  endtask

  // Waits until every expected beat has gone out and the pipe has emptied
  task automatic wait_idle;
    pay_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_START_MARKER:     reg_marker    = val;
      CFG_SENDER_SYSTEM:    reg_src_sys   = val;
      CFG_SENDER_COMPONENT: reg_src_comp  = val;
      CFG_TARGET_SYSTEM:    reg_dst_sys   = val;
      CFG_TARGET_COMPONENT: reg_dst_comp  = val;
      CFG_CRC_EXTRA:        reg_crc_extra = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Programs every register, plus the unused indices, once the block is idle
  task automatic program_regs(input logic [ByteW-1:0] marker, input logic [ByteW-1:0] ssys,
                              input logic [ByteW-1:0] scomp, input logic [ByteW-1:0] tsys,
                              input logic [ByteW-1:0] tcomp, input logic [ByteW-1:0] extra);
    wait_idle();
    write_reg(CFG_START_MARKER, marker);
    write_reg(CFG_SENDER_SYSTEM, ssys);
    write_reg(CFG_SENDER_COMPONENT, scomp);
    write_reg(CFG_TARGET_SYSTEM, tsys);
    write_reg(CFG_TARGET_COMPONENT, tcomp);
    write_reg(CFG_CRC_EXTRA, extra);
    write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
    write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
  endtask

  // Register value biased towards the extremes
  function automatic logic [ByteW-1:0] pick_reg_value;
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Reset register values, one-byte packet and a two-byte packet
  task automatic test_default_header;
    int n;
    send_item(8'h00, 8'd1, 8'h00, 1'b1, n);
    send_item(8'hFF, 8'd2, 8'hFF, 1'b1, n);
    send_item(8'h01, 8'h00, 8'h00, 1'b0, n);
  endtask

  // Stray bytes and zero-length openers, inside and outside a packet
  task automatic test_ignored_items;
    int n;
    send_item(8'hAA, 8'd7, 8'h33, 1'b0, n);
    send_item(8'h55, 8'd0, 8'h12, 1'b1, n);
    send_item(8'h10, 8'd3, 8'h42, 1'b1, n);
    // zero-length opener mid-packet leaves the open packet alone
    send_item(8'h20, 8'd0, 8'h99, 1'b1, n);
    send_item(8'h30, 8'd0, 8'h00, 1'b0, n);
    send_item(8'h40, 8'd9, 8'h00, 1'b0, n);
  endtask

  // Longest length in the header, cut short by a new packet
  task automatic test_abandoned_packet;
    int n;
    send_item(8'h7F, 8'd255, 8'h80, 1'b1, n);
    send_item(8'h80, 8'd255, 8'h80, 1'b0, n);
    send_item(8'hC3, 8'd2, 8'h01, 1'b1, n);
    send_item(8'h3C, 8'h00, 8'h00, 1'b0, n);
  endtask

  // All registers at their top value, then all at zero
  task automatic test_register_extremes;
    int n;
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(8'hFF, 8'd1, 8'hFF, 1'b1, n);
    send_item(8'h5A, 8'd2, 8'h7E, 1'b1, n);
    send_item(8'hA5, 8'd2, 8'h7E, 1'b0, n);
    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(8'h00, 8'd1, 8'h00, 1'b1, n);
  endtask

  // Mostly well-formed packets with random content, some noise and cut
  // packets; four register settings, then one-byte packets until the
  // sequence number has wrapped
  task automatic test_random_traffic;
    int counted;
    int chunk;
    int got;
    int len;
    int sent;
    int pick;
    counted = 0;
    for (chunk = 0; chunk < 4; chunk++) begin
      program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                   pick_reg_value(), pick_reg_value(), pick_reg_value());
      while (counted < RANDOM_ITEMS * (chunk + 1) / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0, got);
          if (got > 0) counted++;
        end else if (pick < 10) begin
          send_item(8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255)),
                    1'b1, got);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      len = 1;
          else if (pick < 80) len = $urandom_range(2, 8);
          else if (pick < 97) len = $urandom_range(9, 30);
          else                len = $urandom_range(100, 255);
          sent = len;
          if (len > 30)
            sent = $urandom_range(1, 12);
          else if (len > 1 && $urandom_range(0, 9) == 0)
            sent = $urandom_range(1, len - 1);
          send_packet(len, 8'($urandom_range(0, 255)), sent, got);
          counted += got;
        end
      end
    end
    while (!seq_wrapped) send_packet(1, 8'($urandom_range(0, 255)), 1, got);
  endtask

  // Full rate on both sides, no idling at all
  task automatic test_back_to_back;
    int k;
    int got;
    int len;
    idle_on = 1'b0;
    for (k = 0; k < 12; k++) begin
      len = $urandom_range(1, 6);
      send_packet(len, 8'($urandom_range(0, 255)), len, got);
    end
  endtask

  initial begin
    int k;
    seq_num       = '0;
    frame_crc     = CRC_SEED;
    bytes_left    = '0;
    seq_wrapped   = 1'b0;
    reg_marker    = RST_MARKER;
    reg_src_sys   = RST_SRC_SYS;
    reg_src_comp  = RST_SRC_COMP;
    reg_dst_sys   = RST_DST_SYS;
    reg_dst_comp  = RST_DST_COMP;
    reg_crc_extra = RST_EXTRA;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_default_header();
    test_ignored_items();
    test_abandoned_packet();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();

    // drain, then allow the pipe to settle so stray beats are caught
    pay_valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && frame_q.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && frame_q.size() == 0)
      $display("mavlink_v1_packet_framer verification clean");
    else
      $display("mavlink_v1_packet_framer verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/mvf_pkg.sv
rtl/mavlink_v1_packet_framer.sv
dv/tb_mavlink_v1_packet_framer.sv
